// File: rtl/core/atce_pkg.sv
// Shared constants, types and byte helpers for the ANSI truecolor cell encoder.
// No dependencies; used by the top level and its testbench.
package atce_pkg;

    // Escape layout: ESC [ k 8 ; 2 ; RRR ; GGG ; BBB m
    localparam int unsigned ESC_LEN = 19;
    localparam int unsigned IDX_W   = $clog2(ESC_LEN);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ESC_LEN - 1);

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Which part of a cell's byte run is being sent
    typedef enum logic [1:0] {
        SEG_FG,
        SEG_BG,
        SEG_CHR,
        SEG_NL
    } t_seg;

    // One ASCII decimal digit of an 8-bit value; pos 0 is hundreds
    function automatic logic [7:0] dec_digit(logic [7:0] v, logic [1:0] pos);
        logic [1:0]  hund;
        logic [7:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        logic [7:0]  res;
        if (v >= 8'd200) begin
            hund = 2'd2;
        end else if (v >= 8'd100) begin
            hund = 2'd1;
        end else begin
            hund = 2'd0;
        end
        rem  = 8'(v - 8'(hund) * 8'd100);
        // rem < 100: divide by ten as multiply by 205 and shift by 11
        prod = 15'(rem[6:0]) * 15'd205;
        tens = prod[14:11];
        ones = 7'(rem[6:0] - 7'(tens) * 7'd10);
        case (pos)
            2'd0:    res = CH_ZERO + 8'(hund);
            2'd1:    res = CH_ZERO + 8'(tens);
            default: res = CH_ZERO + 8'(ones[3:0]);
        endcase
        return res;
    endfunction

    // Byte idx of a colour escape of the given kind ('3' or '4')
    function automatic logic [7:0] esc_byte(logic [7:0] kind, logic [IDX_W-1:0] idx,
                                            logic [23:0] rgb);
        logic [7:0] comp;
        logic [1:0] pos;
        logic [7:0] res;
        if (idx <= IDX_W'(9)) begin
            comp = rgb[23:16];
        end else if (idx <= IDX_W'(13)) begin
            comp = rgb[15:8];
        end else begin
            comp = rgb[7:0];
        end
        case (idx) inside
            IDX_W'(7), IDX_W'(11), IDX_W'(15): pos = 2'd0;
            IDX_W'(8), IDX_W'(12), IDX_W'(16): pos = 2'd1;
            default:                           pos = 2'd2;
        endcase
        case (idx) inside
            IDX_W'(0):                           res = CH_ESC;
            IDX_W'(1):                           res = CH_LBRK;
            IDX_W'(2):                           res = kind;
            IDX_W'(3):                           res = CH_EIGHT;
            IDX_W'(5):                           res = CH_TWO;
            IDX_W'(4), IDX_W'(6), IDX_W'(10),
            IDX_W'(14):                          res = CH_SEMI;
            [IDX_W'(7):IDX_W'(9)],
            [IDX_W'(11):IDX_W'(13)],
            [IDX_W'(15):IDX_W'(17)]:             res = dec_digit(comp, pos);
            default:                             res = CH_M;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/core/atce_if.sv
// Valid/ready channel interfaces of the ANSI truecolor cell encoder.
// Stand-alone; no package needed.
interface atce_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_char;
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
    logic       frame_first;
    logic       row_end;

    modport source (
        output valid, cell_char, fg_red, fg_green, fg_blue,
               bg_red, bg_green, bg_blue, frame_first, row_end,
        input  ready
    );
    modport sink (
        input  valid, cell_char, fg_red, fg_green, fg_blue,
               bg_red, bg_green, bg_blue, frame_first, row_end,
        output ready
    );
endinterface

interface atce_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_cell;

    modport source (output valid, out_byte, last_of_cell, input ready);
    modport sink (input valid, out_byte, last_of_cell, output ready);
endinterface

// File: rtl/core/ansi_truecolor_cell_encoder_unit.sv
// Top level of the ANSI truecolor cell encoder: cells in, terminal bytes out.
// Depends on atce_pkg and the channel interfaces in atce_if.sv.
//
//  channel  | dir | carries
//  ---------+-----+-----------------------------------------------------
//  i_cell   | in  | one character cell: char, fg/bg RGB, frame/row marks
//  o_byte   | out | one stream byte plus last-byte-of-cell flag
//
// One byte leaves per unstalled cycle; a cell is 1 to 40 bytes (escapes 19 bytes
// each, then the char, then an optional newline), set by the byte sequencer.
// A new cell is taken in the cycle its predecessor's last byte is loaded
// into the output register, so unstalled single-byte cells stream at one per cycle.
// Reset (synchronous, active low) clears the sent colours to black and
// empties the sequencer and output register. o_byte.ready low stalls all once it is full.
module ansi_truecolor_cell_encoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    atce_cell_if.sink          i_cell,
    atce_byte_if.source        o_byte
);

    localparam int unsigned IW = atce_pkg::IDX_W;

    // Sequencer and colour state
    logic                  r_busy, n_busy;
    atce_pkg::t_seg        r_seg, n_seg;
    logic [IW-1:0]         r_idx, n_idx;
    logic [23:0]           r_sent_fg, n_sent_fg;
    logic [23:0]           r_sent_bg, n_sent_bg;
    logic [7:0]            r_char, n_char;
    logic                  r_row_end, n_row_end;
    logic                  r_emit_bg, n_emit_bg;

    // Output register
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;

    logic                  out_load;
    logic                  gen_last;
    logic [7:0]            gen_byte;
    logic                  cell_take;
    logic [23:0]           cell_fg;
    logic [23:0]           cell_bg;
    logic                  emit_fg;
    logic                  emit_bg;

    assign cell_fg = {i_cell.fg_red, i_cell.fg_green, i_cell.fg_blue};
    assign cell_bg = {i_cell.bg_red, i_cell.bg_green, i_cell.bg_blue};

    // Decide which escapes a new cell needs
    assign emit_fg = i_cell.frame_first ||
                     (i_cell.cell_char != atce_pkg::CH_SPACE && cell_fg != r_sent_fg);
    assign emit_bg = i_cell.frame_first || (cell_bg != r_sent_bg);

    // Current byte of the run; escapes show the colour just recorded as sent
    always_comb begin
        case (r_seg)
            atce_pkg::SEG_FG:
                gen_byte = atce_pkg::esc_byte(atce_pkg::CH_THREE, r_idx, r_sent_fg);
            atce_pkg::SEG_BG:
                gen_byte = atce_pkg::esc_byte(atce_pkg::CH_FOUR, r_idx, r_sent_bg);
            atce_pkg::SEG_CHR:
                gen_byte = r_char;
            default:
                gen_byte = atce_pkg::CH_NL;
        endcase
    end

    assign gen_last  = (r_seg == atce_pkg::SEG_CHR && !r_row_end) ||
                       (r_seg == atce_pkg::SEG_NL);
    assign out_load  = r_busy && (!r_out_valid || o_byte.ready);
    assign i_cell.ready = !r_busy || (out_load && gen_last);
    assign cell_take = i_cell.valid && i_cell.ready;

    // Advance the sequencer; load a new cell when taken
    always_comb begin
        n_busy    = r_busy;
        n_seg     = r_seg;
        n_idx     = r_idx;
        n_sent_fg = r_sent_fg;
        n_sent_bg = r_sent_bg;
        n_char    = r_char;
        n_row_end = r_row_end;
        n_emit_bg = r_emit_bg;
        if (out_load) begin
            case (r_seg)
                atce_pkg::SEG_FG, atce_pkg::SEG_BG: begin
                    if (r_idx == atce_pkg::IDX_LAST) begin
                        n_idx = '0;
                        n_seg = (r_seg == atce_pkg::SEG_FG && r_emit_bg) ?
                                atce_pkg::SEG_BG : atce_pkg::SEG_CHR;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
                atce_pkg::SEG_CHR: begin
                    if (r_row_end) begin
                        n_seg = atce_pkg::SEG_NL;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
        if (cell_take) begin
            n_busy    = 1'b1;
            n_idx     = '0;
            n_char    = i_cell.cell_char;
            n_row_end = i_cell.row_end;
            n_emit_bg = emit_bg;
            if (emit_fg) begin
                n_sent_fg = cell_fg;
            end
            if (emit_bg) begin
                n_sent_bg = cell_bg;
            end
            if (emit_fg) begin
                n_seg = atce_pkg::SEG_FG;
            end else if (emit_bg) begin
                n_seg = atce_pkg::SEG_BG;
            end else begin
                n_seg = atce_pkg::SEG_CHR;
            end
        end
    end

    // Control and colour state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_seg     <= atce_pkg::SEG_CHR;
            r_idx     <= '0;
            r_sent_fg <= '0;
            r_sent_bg <= '0;
        end else begin
            r_busy    <= n_busy;
            r_seg     <= n_seg;
            r_idx     <= n_idx;
            r_sent_fg <= n_sent_fg;
            r_sent_bg <= n_sent_bg;
        end
    end

    // Cell payload
    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_row_end <= n_row_end;
        r_emit_bg <= n_emit_bg;
    end

    // Output register: load a byte or drop the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_byte.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= gen_byte;
            r_out_last <= gen_last;
        end
    end

    assign o_byte.valid        = r_out_valid;
    assign o_byte.out_byte     = r_out_byte;
    assign o_byte.last_of_cell = r_out_last;

`ifndef SYNTHESIS
    // A first-of-frame cell always starts with the foreground escape
    a_first_starts_fg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cell.valid && i_cell.ready && i_cell.frame_first) |=>
        (r_busy && r_seg == atce_pkg::SEG_FG && r_idx == '0))
        else $error("first cell did not start with fg escape");

    // A new cell is only taken while the previous one finishes
    a_take_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cell.valid && i_cell.ready && r_busy) |-> (out_load && gen_last))
        else $error("cell taken while previous cell still running");

    // The escape byte index never runs past the escape length
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= atce_pkg::IDX_LAST)
        else $error("escape index out of range");

    // The last byte of a cell lands flagged in the output register
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && gen_last) |=> (o_byte.valid && o_byte.last_of_cell))
        else $error("last byte of cell not flagged");
`endif

endmodule

// File: sim/ansi_truecolor_cell_encoder_unit_tb.sv
// Self-checking testbench for the ANSI truecolor cell encoder top level.
// Depends on atce_pkg and the channel interfaces in rtl/core/atce_if.sv.
// Predicts every stream byte from the accepted cells and checks it in order.
module ansi_truecolor_cell_encoder_unit_tb;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_SLACK  = 40;
    localparam int unsigned MAX_PRINTED  = 40;

    typedef struct {
        logic [7:0]  ch;
        logic [23:0] fg;
        logic [23:0] bg;
        logic        first;
        logic        row_end;
    } t_cell_item;

    typedef struct {
        logic [7:0] data;
        logic       is_last;
    } t_stream_byte;

    logic i_clk;
    logic i_rst_n;

    atce_cell_if cell_ch ();
    atce_byte_if byte_ch ();

    ansi_truecolor_cell_encoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_ch),
        .o_byte  (byte_ch)
    );

    // Predictor state: colours last put on the stream
    logic [23:0]  sent_fg;
    logic [23:0]  sent_bg;
    t_stream_byte expected_bytes[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int mismatch_count;
    int items_sent;
    int bytes_checked;
    int fg_escapes;
    int bg_escapes;
    int cycle_count;

    // Free-running clock
    always #2 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, expected_bytes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Drive output ready: low during any hold-off, else random stalls
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            byte_ch.ready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end else begin
            byte_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        end
        mismatch_count++;
    endtask

    // Compare each accepted byte with the oldest prediction
    always @(posedge i_clk) begin : check_stream
        t_stream_byte want;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte 0x%02h last=%0b",
                                          byte_ch.out_byte, byte_ch.last_of_cell));
            end else begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (byte_ch.out_byte !== want.data) begin
                    report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                              byte_ch.out_byte, want.data));
                end
                if (byte_ch.last_of_cell !== want.is_last) begin
                    report_mismatch($sformatf("last_of_cell %0b, want %0b (byte 0x%02h)",
                                              byte_ch.last_of_cell, want.is_last, want.data));
                end
            end
        end
    end

    function automatic void push_stream_byte(input logic [7:0] b, input logic is_last);
        t_stream_byte sb;
        sb.data    = b;
        sb.is_last = is_last;
        expected_bytes.push_back(sb);
    endfunction

    // Three ASCII digits with leading zeros
    function automatic void push_decimal(input logic [7:0] v);
        push_stream_byte(atce_pkg::CH_ZERO + 8'(v / 8'd100), 1'b0);
        push_stream_byte(atce_pkg::CH_ZERO + 8'((v / 8'd10) % 8'd10), 1'b0);
        push_stream_byte(atce_pkg::CH_ZERO + 8'(v % 8'd10), 1'b0);
    endfunction

    function automatic void push_color_escape(input logic [7:0] kind, input logic [23:0] rgb);
        push_stream_byte(atce_pkg::CH_ESC, 1'b0);
        push_stream_byte(atce_pkg::CH_LBRK, 1'b0);
        push_stream_byte(kind, 1'b0);
        push_stream_byte(atce_pkg::CH_EIGHT, 1'b0);
        push_stream_byte(atce_pkg::CH_SEMI, 1'b0);
        push_stream_byte(atce_pkg::CH_TWO, 1'b0);
        push_stream_byte(atce_pkg::CH_SEMI, 1'b0);
        push_decimal(rgb[23:16]);
        push_stream_byte(atce_pkg::CH_SEMI, 1'b0);
        push_decimal(rgb[15:8]);
        push_stream_byte(atce_pkg::CH_SEMI, 1'b0);
        push_decimal(rgb[7:0]);
        push_stream_byte(atce_pkg::CH_M, 1'b0);
    endfunction

    // Work out the bytes one cell puts on the stream and update sent colours
    function automatic void predict_cell_bytes(input t_cell_item it);
        if (it.first) begin
            sent_fg = it.fg;
            sent_bg = it.bg;
            push_color_escape(atce_pkg::CH_THREE, it.fg);
            push_color_escape(atce_pkg::CH_FOUR, it.bg);
            fg_escapes++;
            bg_escapes++;
        end else begin
            // A blank cell shows no foreground, so its colour change is deferred
            if (it.ch != atce_pkg::CH_SPACE && it.fg != sent_fg) begin
                sent_fg = it.fg;
                push_color_escape(atce_pkg::CH_THREE, it.fg);
                fg_escapes++;
            end
            if (it.bg != sent_bg) begin
                sent_bg = it.bg;
                push_color_escape(atce_pkg::CH_FOUR, it.bg);
                bg_escapes++;
            end
        end
        push_stream_byte(it.ch, !it.row_end);
        if (it.row_end) begin
            push_stream_byte(atce_pkg::CH_NL, 1'b1);
        end
    endfunction

    function automatic t_cell_item make_item(input logic [7:0] ch, input logic [23:0] fg,
                                             input logic [23:0] bg, input logic first,
                                             input logic row_end);
        t_cell_item it;
        it.ch      = ch;
        it.fg      = fg;
        it.bg      = bg;
        it.first   = first;
        it.row_end = row_end;
        return it;
    endfunction

    // Offer one item after random idle cycles; hold it until accepted
    task automatic send_item(input t_cell_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            cell_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_ch.valid       <= 1'b1;
        cell_ch.cell_char   <= it.ch;
        cell_ch.fg_red      <= it.fg[23:16];
        cell_ch.fg_green    <= it.fg[15:8];
        cell_ch.fg_blue     <= it.fg[7:0];
        cell_ch.bg_red      <= it.bg[23:16];
        cell_ch.bg_green    <= it.bg[15:8];
        cell_ch.bg_blue     <= it.bg[7:0];
        cell_ch.frame_first <= it.first;
        cell_ch.row_end     <= it.row_end;
        @(posedge i_clk);
        while (!cell_ch.ready) begin
            @(posedge i_clk);
        end
        predict_cell_bytes(it);
        items_sent++;
    endtask

    // Stop offering and wait for every predicted byte
    task automatic drain_output();
        cell_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Before any frame start the sent colours are the reset black
    task automatic test_no_frame_after_reset();
        send_item(make_item(8'h41, 24'h000000, 24'h000000, 1'b0, 1'b0));
        send_item(make_item(8'h42, 24'h102030, 24'h000000, 1'b0, 1'b0));
        send_item(make_item(atce_pkg::CH_SPACE, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0));
        send_item(make_item(atce_pkg::CH_SPACE, 24'hFFFFFF, 24'h0A0B0C, 1'b0, 1'b1));
        send_item(make_item(8'h43, 24'hFFFFFF, 24'h0A0B0C, 1'b0, 1'b0));
        drain_output();
    endtask

    // Frame start forces both escapes, even on a blank cell with no change
    task automatic test_frame_start();
        send_item(make_item(atce_pkg::CH_SPACE, 24'h000000, 24'hFFFFFF, 1'b1, 1'b1));
        send_item(make_item(atce_pkg::CH_SPACE, 24'h000000, 24'hFFFFFF, 1'b1, 1'b1));
        send_item(make_item(atce_pkg::CH_SPACE, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0));
        send_item(make_item(8'h78, 24'h000000, 24'hFFFFFF, 1'b0, 1'b1));
        drain_output();
    endtask

    // Components on every digit boundary
    task automatic test_digit_extremes();
        send_item(make_item(8'h2A, {8'd9, 8'd10, 8'd99}, {8'd100, 8'd199, 8'd200},
                            1'b1, 1'b0));
        send_item(make_item(8'h23, {8'd255, 8'd0, 8'd1}, {8'd254, 8'd55, 8'd128},
                            1'b0, 1'b0));
        send_item(make_item(8'h7E, {8'd200, 8'd100, 8'd99}, 24'hFFFFFF, 1'b0, 1'b1));
        drain_output();
    endtask

    // Char extremes: char byte (plus row-end newline) unless frame start
    task automatic test_char_extremes();
        send_item(make_item(8'h00, {8'd200, 8'd100, 8'd99}, 24'hFFFFFF, 1'b0, 1'b0));
        send_item(make_item(8'hFF, {8'd200, 8'd100, 8'd99}, 24'hFFFFFF, 1'b0, 1'b0));
        send_item(make_item(atce_pkg::CH_NL, {8'd200, 8'd100, 8'd99}, 24'hFFFFFF,
                            1'b0, 1'b1));
        send_item(make_item(atce_pkg::CH_ESC, {8'd200, 8'd100, 8'd99}, 24'hFFFFFF,
                            1'b0, 1'b0));
        send_item(make_item(8'h21, 24'h808080, 24'h7F7F7F, 1'b1, 1'b1));
        drain_output();
    endtask

    // One frame of rows; colours mostly from a small palette so repeats occur.
    // A broken frame lacks its start mark and has row ends at random.
    task automatic send_random_frame(input bit broken);
        logic [23:0] palette[4];
        int          width;
        int          height;
        t_cell_item  it;
        width  = $urandom_range(1, 8);
        height = $urandom_range(1, 3);
        foreach (palette[k]) palette[k] = 24'($urandom);
        for (int r = 0; r < height; r++) begin
            for (int c = 0; c < width; c++) begin
                it.ch      = ($urandom_range(99) < 30) ? atce_pkg::CH_SPACE : 8'($urandom);
                it.fg      = ($urandom_range(99) < 80) ? palette[$urandom_range(3)]
                                                       : 24'($urandom);
                it.bg      = ($urandom_range(99) < 80) ? palette[$urandom_range(3)]
                                                       : 24'($urandom);
                it.first   = !broken && r == 0 && c == 0;
                it.row_end = broken ? 1'($urandom) : (c == width - 1);
                send_item(it);
            end
        end
    endtask

    // Mostly whole frames, some broken ones and some fully random cells
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n_items);
        int target;
        int pick;
        target         = items_sent + n_items;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_random_frame(1'b0);
            end else if (pick < 88) begin
                send_random_frame(1'b1);
            end else begin
                send_item(make_item(8'($urandom), 24'($urandom), 24'($urandom),
                                    1'($urandom), 1'($urandom)));
            end
        end
        drain_output();
    endtask

    // Hold the output off for a long stretch while frame starts keep coming
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles   <= 300;
        for (int k = 0; k < 12; k++) begin
            send_item(make_item(8'($urandom), 24'($urandom), 24'($urandom),
                                1'(k % 3 == 0), 1'($urandom)));
        end
        drain_output();
    endtask

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        cell_ch.valid       = 1'b0;
        cell_ch.cell_char   = '0;
        cell_ch.fg_red      = '0;
        cell_ch.fg_green    = '0;
        cell_ch.fg_blue     = '0;
        cell_ch.bg_red      = '0;
        cell_ch.bg_green    = '0;
        cell_ch.bg_blue     = '0;
        cell_ch.frame_first = 1'b0;
        cell_ch.row_end     = 1'b0;
        byte_ch.ready       = 1'b0;
        sent_fg             = '0;
        sent_bg             = '0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_cycles         = 0;
        mismatch_count      = 0;
        items_sent          = 0;
        bytes_checked       = 0;
        fg_escapes          = 0;
        bg_escapes          = 0;
        cycle_count         = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_frame_after_reset();
        test_frame_start();
        test_digit_extremes();
        test_char_extremes();
        test_output_backpressure();
        test_random_phase(0, 0, 45);
        test_random_phase(53, 0, 45);
        test_random_phase(0, 53, 45);
        test_random_phase(6, 6, 45);

        $display("Covered %0d cells, %0d stream bytes, %0d fg and %0d bg escapes,",
                 items_sent, bytes_checked, fg_escapes, bg_escapes);
        $display("with idle/stall mixes, a long output hold and %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
